>>> hdl/assert_macros.svh
// Assertion macros shared by the deframer's queue and output side.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hdl/slcd_pkg.sv
// Types and constants of the sync/length/checksum deframer.
`default_nettype none
package slcd_pkg;

  localparam logic [7:0]  SYNC_LOW        = 8'hFF;
  localparam logic [7:0]  SYNC_HIGH       = 8'hFE;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd4096;
  localparam int          QUEUE_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_CMD,
    PH_SUM,
    PH_DATA
  } phase_t;

  typedef enum logic {
    OP_DATA   = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_GOOD,
    ST_MISMATCH,
    ST_TOO_LONG
  } status_t;

  // One request from the parser to the output side.
  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [15:0] command;
    logic [15:0] exp_sum;
    status_t     status;
    logic        last;
  } req_t;

endpackage
`default_nettype wire

>>> hdl/sync_length_checksum_deframer.sv
// Byte-serial frame deframer: sync hunt, header parse, payload pass-through, checksum report.
//
// Takes one received byte per request and sustains one byte per clock. The
// front parser hunts for the byte pair FF FE, then reads a little-endian
// 4-byte length, 2-byte command and 2-byte checksum, and turns every payload
// byte and every frame verdict into a request for the output side. A queue of
// QUEUE_DEPTH entries sits between the two, so output back-pressure does not
// stall the parser until the queue fills; in_ready is low only while it is
// full. The output side keeps the 16-bit wrapping payload sum and judges the
// checksum on the last payload byte, which is then flagged with out_last and
// carries the status. A frame with zero length closes with a report
// (out_kind 1) after its checksum; a length above the max_payload_length
// register (cfg_wdata, written with cfg_we, 4096 after reset) closes at once
// with a report of status 2 and command 0. A result is written into the
// queue, then into the output register, and is held there until out_ready
// accepts it. Write the register only while the block is idle.
`default_nettype none
module sync_length_checksum_deframer #(
  parameter int QUEUE_DEPTH = slcd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_byte,
  output logic [15:0]      out_command,
  output logic [1:0]       out_status,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import slcd_pkg::*;

  logic [15:0] max_len_r;
  logic        take;
  logic        push;
  req_t        push_req;
  logic        room;
  logic        pop_valid;
  req_t        pop_req;
  logic        pop;

  // Length limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // Take a byte whenever the queue can hold the request it may cause.
  assign in_ready = room;
  assign take     = in_valid && room;

  slcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .rx_byte  (in_rx_byte),
    .max_len  (max_len_r),
    .push     (push),
    .push_req (push_req)
  );

  slcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_req  (push_req),
    .room      (room),
    .pop_valid (pop_valid),
    .pop_req   (pop_req),
    .pop       (pop)
  );

  slcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_req     (pop_req),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .out_command (out_command),
    .out_status  (out_status),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire

>>> hdl/slcd_front.sv
// Header parser: hunts for sync, reads length, command and checksum, issues requests.
`default_nettype none
module slcd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [15:0]   max_len,
  output logic               push,
  output slcd_pkg::req_t     push_req
);
  import slcd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] esum_r, esum_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] len_full;
  logic [15:0] esum_full;

  assign len_full  = len_r | ({24'h0, rx_byte} << {idx_r, 3'b000});
  assign esum_full = {rx_byte, esum_r[7:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      prev_r  <= '0;
      idx_r   <= '0;
      len_r   <= '0;
      cmd_r   <= '0;
      esum_r  <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      esum_r  <= esum_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    esum_nxt  = esum_r;
    count_nxt = count_r;
    push      = 1'b0;
    push_req  = '{op: OP_DATA, data: rx_byte, command: cmd_r, exp_sum: esum_r,
                  status: ST_GOOD, last: 1'b0};
    if (take) begin
      unique case (phase_r)
        PH_LEN: begin
          len_nxt = len_full;
          if (idx_r == 2'd3) begin
            idx_nxt = '0;
            if (len_full > {16'h0, max_len}) begin
              // drop the frame before any command byte
              push            = 1'b1;
              push_req.op     = OP_REPORT;
              push_req.data   = '0;
              push_req.command = '0;
              push_req.status = ST_TOO_LONG;
              push_req.last   = 1'b1;
              phase_nxt       = PH_HUNT;
              prev_nxt        = '0;
            end else begin
              phase_nxt = PH_CMD;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        PH_CMD: begin
          if (idx_r == 2'd0) begin
            cmd_nxt = {8'h0, rx_byte};
            idx_nxt = 2'd1;
          end else begin
            cmd_nxt   = {rx_byte, cmd_r[7:0]};
            idx_nxt   = '0;
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          if (idx_r == 2'd0) begin
            esum_nxt = {8'h0, rx_byte};
            idx_nxt  = 2'd1;
          end else begin
            esum_nxt  = esum_full;
            idx_nxt   = '0;
            count_nxt = '0;
            if (len_r == 32'h0) begin
              push            = 1'b1;
              push_req.op     = OP_REPORT;
              push_req.data   = '0;
              push_req.status = (esum_full != 16'h0) ? ST_MISMATCH : ST_GOOD;
              push_req.last   = 1'b1;
              phase_nxt       = PH_HUNT;
              prev_nxt        = '0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          count_nxt     = count_r + 16'd1;
          push          = 1'b1;
          push_req.last = (count_nxt == len_r[15:0]);
          if (push_req.last) begin
            phase_nxt = PH_HUNT;
            prev_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (prev_r == SYNC_LOW && rx_byte == SYNC_HIGH) begin
            phase_nxt = PH_LEN;
            idx_nxt   = '0;
            len_nxt   = '0;
            cmd_nxt   = '0;
            esum_nxt  = '0;
            count_nxt = '0;
            prev_nxt  = '0;
          end else begin
            prev_nxt = rx_byte;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/slcd_queue.sv
// Short request queue between the parser and the output side.
`default_nettype none
`include "assert_macros.svh"
module slcd_queue #(
  parameter int DEPTH = slcd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire slcd_pkg::req_t push_req,
  output logic                room,
  output logic                pop_valid,
  output slcd_pkg::req_t      pop_req,
  input  wire logic           pop
);
  import slcd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign room      = (count_r != CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_req   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && !pop && !room)
  `ASSERT_CLK(a_drain_empty, clk, rst_n, (count_r == CW'(1) && pop && !push) |=> !pop_valid)

endmodule
`default_nettype wire

>>> hdl/slcd_back.sv
// Output side: running payload sum, checksum verdict and the output register.
`default_nettype none
`include "assert_macros.svh"
module slcd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  input  wire slcd_pkg::req_t pop_req,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_kind,
  output logic [7:0]          out_byte,
  output logic [15:0]         out_command,
  output logic [1:0]          out_status,
  output logic                out_last
);
  import slcd_pkg::*;

  logic [15:0] sum_r, sum_nxt;
  logic [15:0] sum_add;
  status_t     status;
  logic        out_valid_r;
  op_t         out_kind_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_command_r;
  status_t     out_status_r;
  logic        out_last_r;

  assign pop     = pop_valid && (!out_valid_r || out_ready);
  assign sum_add = sum_r + {8'h0, pop_req.data};

  always_comb begin
    sum_nxt = sum_r;
    status  = pop_req.status;
    if (pop && pop_req.op == OP_DATA) begin
      status  = (pop_req.last && sum_add != pop_req.exp_sum) ? ST_MISMATCH : ST_GOOD;
      sum_nxt = pop_req.last ? 16'h0 : sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind_r    <= pop_req.op;
      out_byte_r    <= pop_req.data;
      out_command_r <= pop_req.command;
      out_status_r  <= status;
      out_last_r    <= pop_req.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_byte    = out_byte_r;
  assign out_command = out_command_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

  `ASSERT_NEVER(a_report_closes, clk, rst_n, out_valid_r && out_kind_r == OP_REPORT && !out_last_r)
  `ASSERT_NEVER(a_status_on_last, clk, rst_n, out_valid_r && !out_last_r && out_status_r != ST_GOOD)
  `ASSERT_CLK(a_sum_cleared, clk, rst_n, (pop && pop_req.op == OP_DATA && pop_req.last) |=> sum_r == 16'h0)

endmodule
`default_nettype wire
